// ===== rtl/core/ptlc_pkg.sv =====
package ptlc_pkg;

  // Field widths
  localparam int SAMPLE_W    = 10;
  localparam int RUN_W       = 13;
  localparam int PERIOD_W    = 16;
  localparam int SYNC_W      = 8;
  localparam int REG_INDEX_W = 2;
  localparam int REG_DATA_W  = 16;

  // Register indexes of the configuration port
  localparam logic [REG_INDEX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_RUN_LIMIT       = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_GREEN_LIMIT     = 2'd2;
  localparam logic [REG_INDEX_W-1:0] REG_SYNC_INTERVAL   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [SAMPLE_W-1:0] LEVEL_THRESHOLD_RST = 10'd300;
  localparam logic [RUN_W-1:0]    RUN_LIMIT_RST       = 13'd4800;
  localparam logic [PERIOD_W-1:0] GREEN_LIMIT_RST     = 16'd21600;
  localparam logic [SYNC_W-1:0]   SYNC_INTERVAL_RST   = 8'd240;

  // Run timer saturates here
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // Input item function codes
  localparam logic FUNC_CONTROL = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ON   = 2'd1,
    PH_DEC  = 2'd2,
    PH_OFF  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level_threshold;
    logic [RUN_W-1:0]    run_limit_seconds;
    logic [PERIOD_W-1:0] green_limit_seconds;
    logic [SYNC_W-1:0]   sync_interval;
  } cfg_t;

  typedef struct packed {
    phase_t              run_phase;
    logic                timer_mode_flag;
    logic                motor_running;
    logic                low_latched;
    logic                mid_latched;
    logic [RUN_W-1:0]    run_seconds;
    logic                time_over;
    logic [SYNC_W-1:0]   sync_count;
    logic                sync_pending;
    logic [PERIOD_W-1:0] period_seconds;
    logic                green_flag;
  } state_t;

  localparam state_t STATE_RST = '{
    run_phase:       PH_OFF,
    timer_mode_flag: 1'b0,
    motor_running:   1'b0,
    low_latched:     1'b0,
    mid_latched:     1'b0,
    run_seconds:     '0,
    time_over:       1'b0,
    sync_count:      '0,
    sync_pending:    1'b0,
    period_seconds:  '0,
    green_flag:      1'b0
  };

  typedef struct packed {
    logic                func;
    logic                button;
    logic [SAMPLE_W-1:0] low_level_sample;
    logic [SAMPLE_W-1:0] mid_level_sample;
  } item_t;

  typedef struct packed {
    logic motor_on;
    logic start_issued;
    logic stop_issued;
    logic sync_request;
    logic green_period;
    logic in_timer_mode;
  } result_t;

endpackage

// ===== rtl/core/ptlc_in_if.sv =====
interface ptlc_in_if;
  import ptlc_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic                button;
  logic [SAMPLE_W-1:0] low_level_sample;
  logic [SAMPLE_W-1:0] mid_level_sample;

  modport source (
    output valid, func, button, low_level_sample, mid_level_sample,
    input  ready
  );

  modport sink (
    input  valid, func, button, low_level_sample, mid_level_sample,
    output ready
  );
endinterface

// ===== rtl/core/ptlc_out_if.sv =====
interface ptlc_out_if;
  logic valid;
  logic ready;
  logic motor_on;
  logic start_issued;
  logic stop_issued;
  logic sync_request;
  logic green_period;
  logic in_timer_mode;

  modport source (
    output valid, motor_on, start_issued, stop_issued, sync_request,
           green_period, in_timer_mode,
    input  ready
  );

  modport sink (
    input  valid, motor_on, start_issued, stop_issued, sync_request,
           green_period, in_timer_mode,
    output ready
  );
endinterface

// ===== rtl/core/ptlc_step.sv =====
module ptlc_step (
  input  ptlc_pkg::cfg_t    cfg,
  input  ptlc_pkg::state_t  state,
  input  ptlc_pkg::item_t   item,
  output ptlc_pkg::state_t  state_next,
  output ptlc_pkg::result_t result_next
);
  import ptlc_pkg::*;

  always_comb begin
    state_t s;
    logic   did_start;
    logic   did_stop;
    logic   sync_now;
    logic   low_wet;
    logic   mid_wet;

    s         = state;
    did_start = 1'b0;
    did_stop  = 1'b0;
    sync_now  = 1'b0;
    low_wet   = item.low_level_sample < cfg.level_threshold;
    mid_wet   = item.mid_level_sample < cfg.level_threshold;

    if (item.func == FUNC_TICK) begin
      // Advance the sync divider
      if (s.sync_count == cfg.sync_interval) begin
        s.sync_pending = 1'b1;
        s.sync_count   = '0;
      end else begin
        s.sync_count = s.sync_count + 1'b1;
      end
      // Advance the run timer while a timed run counts
      if (s.run_phase == PH_DEC) begin
        if (s.run_seconds > cfg.run_limit_seconds || s.run_seconds == RUN_MAX) begin
          s.time_over = 1'b1;
        end else begin
          s.run_seconds = s.run_seconds + 1'b1;
        end
      end
      // Free-running period counter wraps
      s.period_seconds = s.period_seconds + 1'b1;
    end else begin
      // Send any pending sync request
      sync_now       = s.sync_pending;
      s.sync_pending = 1'b0;
      s.green_flag   = s.period_seconds < cfg.green_limit_seconds;

      // Button starts a timed run or cancels a counting one
      if (item.button) begin
        if (s.run_phase == PH_DEC) begin
          s.run_phase = PH_OFF;
        end else begin
          s.timer_mode_flag = 1'b1;
          s.run_phase       = PH_ON;
        end
      end

      if (s.timer_mode_flag) begin
        // Timed-run sequencer
        unique case (s.run_phase)
          PH_ON: begin
            s.motor_running = 1'b1;
            did_start       = 1'b1;
            s.run_seconds   = '0;
            s.run_phase     = PH_DEC;
          end
          PH_DEC: begin
            if (s.time_over) begin
              s.time_over = 1'b0;
              s.run_phase = PH_OFF;
            end
          end
          PH_OFF: begin
            s.motor_running   = 1'b0;
            did_stop          = 1'b1;
            s.time_over       = 1'b0;
            s.timer_mode_flag = 1'b0;
            s.run_phase       = PH_WAIT;
          end
          default: begin
          end
        endcase
      end else if (!s.green_flag) begin
        // Red period: force the motor off
        if (s.motor_running) begin
          s.motor_running = 1'b0;
          did_stop        = 1'b1;
          s.mid_latched   = 1'b0;
          s.low_latched   = 1'b0;
        end
      end else begin
        // Hysteretic start on the middle sensor, stop on the lower one
        if (mid_wet && !s.mid_latched) begin
          s.low_latched   = 1'b0;
          s.mid_latched   = 1'b1;
          s.motor_running = 1'b1;
          did_start       = 1'b1;
        end
        if (!low_wet && !s.low_latched) begin
          s.low_latched   = 1'b1;
          s.mid_latched   = 1'b0;
          s.motor_running = 1'b0;
          did_stop        = 1'b1;
        end
      end
    end

    state_next                = s;
    result_next.motor_on      = s.motor_running;
    result_next.start_issued  = did_start;
    result_next.stop_issued   = did_stop;
    result_next.sync_request  = sync_now;
    result_next.green_period  = s.green_flag;
    result_next.in_timer_mode = s.timer_mode_flag;
  end

endmodule

// ===== rtl/core/pump_timer_level_controller_unit.sv =====
// An accepted request passes through the input register, then the result
// register, which holds its result until it is taken.
// One request per cycle while results are taken; the input register can
// still take a request while a result waits to be taken, if it is empty.
// Reset (rst, synchronous, active high) clears the controller state, the
// valid flags, and loads the configuration registers with their defaults.
module pump_timer_level_controller_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  write_enable,
  input  logic [ptlc_pkg::REG_INDEX_W-1:0]      reg_index,
  input  logic [ptlc_pkg::REG_DATA_W-1:0]       write_data,
  ptlc_in_if.sink                               item,
  ptlc_out_if.source                            result
);
  import ptlc_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   item_reg;
  logic    item_valid;
  result_t result_reg;
  result_t result_next;
  logic    result_valid;
  logic    advance;

  // Step moves into the result register when it is free or being drained
  assign advance    = item_valid && (!result_valid || result.ready);
  assign item.ready = !item_valid || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_threshold     <= LEVEL_THRESHOLD_RST;
      cfg.run_limit_seconds   <= RUN_LIMIT_RST;
      cfg.green_limit_seconds <= GREEN_LIMIT_RST;
      cfg.sync_interval       <= SYNC_INTERVAL_RST;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_LEVEL_THRESHOLD: cfg.level_threshold     <= write_data[SAMPLE_W-1:0];
        REG_RUN_LIMIT:       cfg.run_limit_seconds   <= write_data[RUN_W-1:0];
        REG_GREEN_LIMIT:     cfg.green_limit_seconds <= write_data[PERIOD_W-1:0];
        REG_SYNC_INTERVAL:   cfg.sync_interval       <= write_data[SYNC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item.ready) begin
      item_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_reg.func             <= item.func;
      item_reg.button           <= item.button;
      item_reg.low_level_sample <= item.low_level_sample;
      item_reg.mid_level_sample <= item.mid_level_sample;
    end
  end

  ptlc_step u_step (
    .cfg         (cfg),
    .state       (state),
    .item        (item_reg),
    .state_next  (state_next),
    .result_next (result_next)
  );

  // Controller state updates as the request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RST;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result_next;
    end
  end

  assign result.valid         = result_valid;
  assign result.motor_on      = result_reg.motor_on;
  assign result.start_issued  = result_reg.start_issued;
  assign result.stop_issued   = result_reg.stop_issued;
  assign result.sync_request  = result_reg.sync_request;
  assign result.green_period  = result_reg.green_period;
  assign result.in_timer_mode = result_reg.in_timer_mode;

endmodule

// ===== verif/pump_timer_level_controller_unit_tb.sv =====
module pump_timer_level_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptlc_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [REG_INDEX_W-1:0] reg_index;
  logic [REG_DATA_W-1:0]  write_data;

  ptlc_in_if  request_ch ();
  ptlc_out_if result_ch ();

  pump_timer_level_controller_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .item         (request_ch),
    .result       (result_ch)
  );

  // Predicted configuration
  logic [SAMPLE_W-1:0] level_thr;
  logic [RUN_W-1:0]    run_lim;
  logic [PERIOD_W-1:0] green_lim;
  logic [SYNC_W-1:0]   sync_div;

  // Predicted controller state
  phase_t              timer_phase;
  logic                timer_on;
  logic                motor;
  logic                low_hit;
  logic                mid_hit;
  logic [RUN_W-1:0]    run_secs;
  logic                run_expired;
  logic [SYNC_W-1:0]   tick_div;
  logic                sync_due;
  logic [PERIOD_W-1:0] period;
  logic                green;

  item_t       pending_q[$];
  result_t     due_status_q[$];
  item_t       offered;
  int unsigned pushed_count;
  int unsigned accepted_count;
  int unsigned error_count;
  int unsigned send_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  logic        sink_hold;
  logic        idle_on;

  always #5 clk = ~clk;

  // Advance the predicted controller by one request, return the status it yields
  function automatic result_t pump_step(item_t req);
    result_t st;
    logic    started;
    logic    stopped;
    logic    sync_out;
    logic    low_wet;
    logic    mid_wet;
    started  = 1'b0;
    stopped  = 1'b0;
    sync_out = 1'b0;
    if (req.func == FUNC_TICK) begin
      if (tick_div == sync_div) begin
        sync_due = 1'b1;
        tick_div = '0;
      end else begin
        tick_div++;
      end
      if (timer_phase == PH_DEC) begin
        if (run_secs > run_lim || run_secs == RUN_MAX) run_expired = 1'b1;
        else run_secs++;
      end
      period++;
    end else begin
      if (sync_due) begin
        sync_due = 1'b0;
        sync_out = 1'b1;
      end
      green = period < green_lim;
      if (req.button) begin
        if (timer_phase == PH_DEC) begin
          timer_phase = PH_OFF;
        end else begin
          timer_on    = 1'b1;
          timer_phase = PH_ON;
        end
      end
      if (timer_on) begin
        case (timer_phase)
          PH_ON: begin
            motor       = 1'b1;
            started     = 1'b1;
            run_secs    = '0;
            timer_phase = PH_DEC;
          end
          PH_DEC: begin
            if (run_expired) begin
              run_expired = 1'b0;
              timer_phase = PH_OFF;
            end
          end
          PH_OFF: begin
            motor       = 1'b0;
            stopped     = 1'b1;
            run_expired = 1'b0;
            timer_on    = 1'b0;
            timer_phase = PH_WAIT;
          end
          default: ;
        endcase
      end else if (!green) begin
        // Red period: force the motor off
        if (motor) begin
          motor   = 1'b0;
          stopped = 1'b1;
          mid_hit = 1'b0;
          low_hit = 1'b0;
        end
      end else begin
        low_wet = req.low_level_sample < level_thr;
        mid_wet = req.mid_level_sample < level_thr;
        if (mid_wet && !mid_hit) begin
          low_hit = 1'b0;
          mid_hit = 1'b1;
          motor   = 1'b1;
          started = 1'b1;
        end
        if (!low_wet && !low_hit) begin
          low_hit = 1'b1;
          mid_hit = 1'b0;
          motor   = 1'b0;
          stopped = 1'b1;
        end
      end
    end
    st.motor_on      = motor;
    st.start_issued  = started;
    st.stop_issued   = stopped;
    st.sync_request  = sync_out;
    st.green_period  = green;
    st.in_timer_mode = timer_on;
    return st;
  endfunction

  // Mostly back to back, sometimes short pauses, rarely long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Favor samples around the threshold so the hysteresis flips
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1023);
      1: v = $urandom_range(0, 1) ? 1023 : 0;
      default: v = int'(level_thr) + int'($urandom_range(0, 8)) - 4;
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_W'(v);
  endfunction

  task automatic push_item(logic func, logic button, int unsigned low, int unsigned mid);
    item_t req;
    req.func             = func;
    req.button           = button;
    req.low_level_sample = SAMPLE_W'(low);
    req.mid_level_sample = SAMPLE_W'(mid);
    pending_q.push_back(req);
    pushed_count++;
  endtask

  task automatic push_random();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) push_item(FUNC_TICK, 1'($urandom()), pick_sample(), pick_sample());
    else push_item(FUNC_CONTROL, roll >= 90, pick_sample(), pick_sample());
  endtask

  // Write one register; upper data bits carry junk that must be dropped
  task automatic cfg_write(logic [REG_INDEX_W-1:0] idx, int unsigned value);
    logic [REG_DATA_W-1:0] data;
    data = REG_DATA_W'($urandom());
    case (idx)
      REG_LEVEL_THRESHOLD: begin
        data[SAMPLE_W-1:0] = value[SAMPLE_W-1:0];
        level_thr = data[SAMPLE_W-1:0];
      end
      REG_RUN_LIMIT: begin
        data[RUN_W-1:0] = value[RUN_W-1:0];
        run_lim = data[RUN_W-1:0];
      end
      REG_GREEN_LIMIT: begin
        data[PERIOD_W-1:0] = value[PERIOD_W-1:0];
        green_lim = data[PERIOD_W-1:0];
      end
      REG_SYNC_INTERVAL: begin
        data[SYNC_W-1:0] = value[SYNC_W-1:0];
        sync_div = data[SYNC_W-1:0];
      end
    endcase
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= data;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) cfg_write(REG_LEVEL_THRESHOLD, 0);
    else if (roll == 1) cfg_write(REG_LEVEL_THRESHOLD, 1023);
    else cfg_write(REG_LEVEL_THRESHOLD, $urandom_range(1, 1022));
    roll = $urandom_range(0, 7);
    if (roll < 2) cfg_write(REG_RUN_LIMIT, 1);
    else if (roll == 2) cfg_write(REG_RUN_LIMIT, 8191);
    else cfg_write(REG_RUN_LIMIT, $urandom_range(2, 25));
    roll = $urandom_range(0, 7);
    if (roll == 0) cfg_write(REG_GREEN_LIMIT, 0);
    else if (roll == 1) cfg_write(REG_GREEN_LIMIT, 65535);
    else cfg_write(REG_GREEN_LIMIT, int'(period) + $urandom_range(0, 60));
    roll = $urandom_range(0, 7);
    if (roll == 0) cfg_write(REG_SYNC_INTERVAL, 0);
    else if (roll == 1) cfg_write(REG_SYNC_INTERVAL, 255);
    else cfg_write(REG_SYNC_INTERVAL, $urandom_range(1, 12));
  endtask

  // Hold until every pushed request is taken and every status has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_count != pushed_count || due_status_q.size() != 0);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      request_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (request_ch.valid && request_ch.ready) begin
        due_status_q.push_back(pump_step(offered));
        accepted_count++;
      end
      if (!request_ch.valid || request_ch.ready) begin
        if (send_gap > 0) begin
          request_ch.valid <= 1'b0;
          send_gap--;
        end else if (pending_q.size() > 0) begin
          offered = pending_q.pop_front();
          request_ch.func             <= offered.func;
          request_ch.button           <= offered.button;
          request_ch.low_level_sample <= offered.low_level_sample;
          request_ch.mid_level_sample <= offered.mid_level_sample;
          request_ch.valid            <= 1'b1;
          send_gap = pick_gap();
        end else begin
          request_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_bit(string field, logic want, logic got);
    if (got !== want) begin
      $display("%0t: %s expected %0b got %0b", $time, field, want, got);
      error_count++;
    end
  endtask

  // Status monitor
  always @(posedge clk) begin : status_monitor
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (due_status_q.size() == 0) begin
          $display("%0t: unexpected status expected none got %b", $time,
                   {result_ch.motor_on, result_ch.start_issued, result_ch.stop_issued,
                    result_ch.sync_request, result_ch.green_period,
                    result_ch.in_timer_mode});
          error_count++;
        end else begin
          want = due_status_q.pop_front();
          compare_bit("motor_on", want.motor_on, result_ch.motor_on);
          compare_bit("start_issued", want.start_issued, result_ch.start_issued);
          compare_bit("stop_issued", want.stop_issued, result_ch.stop_issued);
          compare_bit("sync_request", want.sync_request, result_ch.sync_request);
          compare_bit("green_period", want.green_period, result_ch.green_period);
          compare_bit("in_timer_mode", want.in_timer_mode, result_ch.in_timer_mode);
        end
      end
      if (sink_hold) begin
        result_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        result_ch.ready <= 1'b0;
        sink_gap--;
      end else begin
        result_ch.ready <= 1'b1;
        sink_gap = pick_gap();
      end
    end
  end

  // Long back-pressure window, counted down here
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    sink_hold <= (hold_left > 0);
  end

  initial begin
    #10ms;
    $display("pump_timer_level_controller_unit_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    clk                         = 1'b0;
    rst                         = 1'b1;
    write_enable                = 1'b0;
    reg_index                   = '0;
    write_data                  = '0;
    request_ch.valid            = 1'b0;
    request_ch.func             = FUNC_CONTROL;
    request_ch.button           = 1'b0;
    request_ch.low_level_sample = '0;
    request_ch.mid_level_sample = '0;
    result_ch.ready             = 1'b0;
    sink_hold                   = 1'b0;
    hold_left                   = 0;
    idle_on                     = 1'b1;
    pushed_count                = 0;
    accepted_count              = 0;
    error_count                 = 0;
    level_thr   = LEVEL_THRESHOLD_RST;
    run_lim     = RUN_LIMIT_RST;
    green_lim   = GREEN_LIMIT_RST;
    sync_div    = SYNC_INTERVAL_RST;
    timer_phase = PH_OFF;
    timer_on    = 1'b0;
    motor       = 1'b0;
    low_hit     = 1'b0;
    mid_hit     = 1'b0;
    run_secs    = '0;
    run_expired = 1'b0;
    tick_div    = '0;
    sync_due    = 1'b0;
    period      = '0;
    green       = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Auto mode under default settings: start, stop, both in one pass, boundaries
    push_item(FUNC_CONTROL, 0, 0, 0);
    push_item(FUNC_CONTROL, 0, 1023, 1023);
    push_item(FUNC_CONTROL, 0, 1023, 0);
    push_item(FUNC_CONTROL, 0, 299, 300);
    push_item(FUNC_CONTROL, 0, 300, 299);
    push_item(FUNC_TICK, 1, 1023, 0);
    // Timed run: start, count, cancel by button, start again, cancel at once
    push_item(FUNC_CONTROL, 1, 0, 0);
    repeat (3) push_item(FUNC_TICK, 0, 0, 0);
    push_item(FUNC_CONTROL, 0, 512, 512);
    push_item(FUNC_CONTROL, 1, 0, 0);
    push_item(FUNC_CONTROL, 0, 0, 0);
    push_item(FUNC_CONTROL, 1, 1023, 1023);
    push_item(FUNC_CONTROL, 1, 1023, 1023);
    wait_drained();

    // Run limit of 1, sync on every tick, widest threshold, always red
    cfg_write(REG_LEVEL_THRESHOLD, 1023);
    cfg_write(REG_RUN_LIMIT, 1);
    cfg_write(REG_GREEN_LIMIT, 0);
    cfg_write(REG_SYNC_INTERVAL, 0);
    @(negedge clk);
    push_item(FUNC_CONTROL, 1, 0, 0);
    repeat (3) push_item(FUNC_TICK, 0, 0, 0);
    push_item(FUNC_CONTROL, 0, 0, 0);
    push_item(FUNC_CONTROL, 0, 0, 0);
    push_item(FUNC_CONTROL, 0, 1023, 1022);
    wait_drained();

    // Random phases with fresh settings each time
    for (int phase = 0; phase < 10; phase++) begin
      idle_on = (phase != 4);
      random_config();
      @(negedge clk);
      if (phase == 2) hold_left = 300;
      repeat (105) push_random();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("pump_timer_level_controller_unit_tb: PASS");
    end else begin
      $display("pump_timer_level_controller_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
